FILE: rtl/p2c_pkg.sv
// Package: fixed-point constants and shared types for the polar to Cartesian converter.
package p2c_pkg;

	// Q1.61 fixed point for angles, sine and cosine
	localparam int FRAC = 61;
	localparam int Q_W = 62;
	localparam int SUM_W = 64;
	localparam logic [SUM_W-1:0] Q_ONE = 64'd1 << FRAC;

	// Taylor series length and latency of the pipelined wide multiplier
	localparam int SERIES_TERMS = 14;
	localparam int MUL_LAT = 2;
	localparam int TERM_LAT = 2 * MUL_LAT;

	// Exact floor division by the small series denominators: q = (x * m) >> RECIP_SHIFT,
	// m = ceil(2^72 / d), exact for x < 2^62 and d < 1024
	localparam int RECIP_W = 72;
	localparam int RECIP_SHIFT = 72;
	localparam logic [RECIP_W:0] TWO_72 = 73'd1 << RECIP_SHIFT;

	// Orientation register
	localparam int MODE_W = 3;
	localparam int MODE_NEG_X = 0;
	localparam int MODE_NEG_Y = 1;
	localparam int MODE_SWAP = 2;

	typedef enum logic [1:0] {
		QUAD_I   = 2'd0,
		QUAD_II  = 2'd1,
		QUAD_III = 2'd2,
		QUAD_IV  = 2'd3
	} quad_t;

	// atan(1/5) by the alternating series, truncated as in the fixed-point definition
	localparam logic [SUM_W-1:0] A5_P0 = Q_ONE / 64'd5;
	localparam logic [SUM_W-1:0] A5_P1 = A5_P0 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P2 = A5_P1 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P3 = A5_P2 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P4 = A5_P3 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P5 = A5_P4 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P6 = A5_P5 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P7 = A5_P6 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P8 = A5_P7 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P9 = A5_P8 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P10 = A5_P9 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P11 = A5_P10 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P12 = A5_P11 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P13 = A5_P12 / 64'd25;
	localparam logic [SUM_W-1:0] A5_P14 = A5_P13 / 64'd25;
	localparam logic [SUM_W-1:0] ATAN_5 = A5_P0 - A5_P1 / 64'd3 + A5_P2 / 64'd5
		- A5_P3 / 64'd7 + A5_P4 / 64'd9 - A5_P5 / 64'd11 + A5_P6 / 64'd13
		- A5_P7 / 64'd15 + A5_P8 / 64'd17 - A5_P9 / 64'd19 + A5_P10 / 64'd21
		- A5_P11 / 64'd23 + A5_P12 / 64'd25 - A5_P13 / 64'd27 + A5_P14 / 64'd29;

	// atan(1/239)
	localparam logic [SUM_W-1:0] A239_P0 = Q_ONE / 64'd239;
	localparam logic [SUM_W-1:0] A239_P1 = A239_P0 / 64'd57121;
	localparam logic [SUM_W-1:0] A239_P2 = A239_P1 / 64'd57121;
	localparam logic [SUM_W-1:0] A239_P3 = A239_P2 / 64'd57121;
	localparam logic [SUM_W-1:0] ATAN_239 = A239_P0 - A239_P1 / 64'd3 + A239_P2 / 64'd5
		- A239_P3 / 64'd7;

	// pi/2 by Machin's formula
	localparam logic [SUM_W-1:0] HALF_PI = 64'd8 * ATAN_5 - 64'd2 * ATAN_239;

	// reciprocals of (2k)(2k+1) for the sine terms
	localparam logic [RECIP_W-1:0] SIN_RECIP [SERIES_TERMS] = '{
		RECIP_W'((TWO_72 + 73'd5) / 73'd6),
		RECIP_W'((TWO_72 + 73'd19) / 73'd20),
		RECIP_W'((TWO_72 + 73'd41) / 73'd42),
		RECIP_W'((TWO_72 + 73'd71) / 73'd72),
		RECIP_W'((TWO_72 + 73'd109) / 73'd110),
		RECIP_W'((TWO_72 + 73'd155) / 73'd156),
		RECIP_W'((TWO_72 + 73'd209) / 73'd210),
		RECIP_W'((TWO_72 + 73'd271) / 73'd272),
		RECIP_W'((TWO_72 + 73'd341) / 73'd342),
		RECIP_W'((TWO_72 + 73'd419) / 73'd420),
		RECIP_W'((TWO_72 + 73'd505) / 73'd506),
		RECIP_W'((TWO_72 + 73'd599) / 73'd600),
		RECIP_W'((TWO_72 + 73'd701) / 73'd702),
		RECIP_W'((TWO_72 + 73'd811) / 73'd812)
	};

	// reciprocals of (2k-1)(2k) for the cosine terms
	localparam logic [RECIP_W-1:0] COS_RECIP [SERIES_TERMS] = '{
		RECIP_W'((TWO_72 + 73'd1) / 73'd2),
		RECIP_W'((TWO_72 + 73'd11) / 73'd12),
		RECIP_W'((TWO_72 + 73'd29) / 73'd30),
		RECIP_W'((TWO_72 + 73'd55) / 73'd56),
		RECIP_W'((TWO_72 + 73'd89) / 73'd90),
		RECIP_W'((TWO_72 + 73'd131) / 73'd132),
		RECIP_W'((TWO_72 + 73'd181) / 73'd182),
		RECIP_W'((TWO_72 + 73'd239) / 73'd240),
		RECIP_W'((TWO_72 + 73'd305) / 73'd306),
		RECIP_W'((TWO_72 + 73'd379) / 73'd380),
		RECIP_W'((TWO_72 + 73'd461) / 73'd462),
		RECIP_W'((TWO_72 + 73'd551) / 73'd552),
		RECIP_W'((TWO_72 + 73'd649) / 73'd650),
		RECIP_W'((TWO_72 + 73'd755) / 73'd756)
	};

endpackage

FILE: rtl/p2c_in_if.sv
// Interface: polar request channel (azimuth and range) with valid/ready handshake.
interface p2c_in_if #(
	parameter int ANGLE_BITS = 16,
	parameter int RANGE_BITS = 20
);
	logic                  valid;
	logic                  ready;
	logic [ANGLE_BITS-1:0] azimuth;
	logic [RANGE_BITS-1:0] range_m;

	modport source (output valid, azimuth, range_m, input ready);
	modport sink (input valid, azimuth, range_m, output ready);
endinterface

FILE: rtl/p2c_out_if.sv
// Interface: Cartesian result channel (x and y) with valid/ready handshake.
interface p2c_out_if #(
	parameter int RANGE_BITS = 20
);
	logic                         valid;
	logic                         ready;
	logic signed [RANGE_BITS:0]   x_out;
	logic signed [RANGE_BITS:0]   y_out;

	modport source (output valid, x_out, y_out, input ready);
	modport sink (input valid, x_out, y_out, output ready);
endinterface

FILE: rtl/polar_to_cartesian_oriented_top.sv
// Top level: pipelined polar to Cartesian converter with selectable axis orientation.
//
// Usage
//   Requests enter on the polar channel (azimuth as a binary angle, range in metres) and
//   results leave on the cart channel (x_out, y_out, two's complement metres, rounded to
//   the nearest metre). Both channels move one request when valid and ready are high.
//   cfg_we/cfg_data write the 3-bit orientation mode: bit 2 puts cosine on x and sine on
//   y, bit 0 negates x, bit 1 negates y. Write it only while no request is in flight.
// Timing
//   One request per cycle while the output is not stalled. The pipeline has these stages:
//   1 input stage, 4 for the angle scaling and its square, 56 for the 14-term
//   sine/cosine series (two multiplier passes per term), 1 quadrant select, 2 for the
//   range product and 1 output stage.
// Reset
//   arst_n clears all stage valid bits and the mode (sensor-up orientation, mode 0).
// Stall
//   When the output register holds a result that is not taken, the whole pipeline holds
//   and polar.ready drops in the same cycle; it rises again as soon as cart.ready does.
module polar_to_cartesian_oriented_top #(
	parameter int ANGLE_BITS = 16,
	parameter int RANGE_BITS = 20
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [p2c_pkg::MODE_W-1:0] cfg_data,
	p2c_in_if.sink                     polar,
	p2c_out_if.source                  cart
);
	localparam int PHI_W = ANGLE_BITS - 2;
	localparam int Q_W = p2c_pkg::Q_W;
	localparam int SUM_W = p2c_pkg::SUM_W;
	localparam int N_TERMS = p2c_pkg::SERIES_TERMS;
	localparam int MUL_LAT = p2c_pkg::MUL_LAT;
	localparam int TERM_LAT = p2c_pkg::TERM_LAT;
	localparam int SCL_W = RANGE_BITS + 2;
	localparam int OUT_W = RANGE_BITS + 1;

	// stage indexes of the sideband line
	localparam int I_SERIES = 2 * MUL_LAT + N_TERMS * TERM_LAT;
	localparam int I_SEL = I_SERIES + 1;
	localparam int I_SCALE = I_SEL + MUL_LAT;
	localparam int LAT = I_SCALE + 2;

	localparam logic [PHI_W:0]   QUARTER = (PHI_W + 1)'(1) << PHI_W;
	localparam logic [PHI_W-1:0] EIGHTH = PHI_W'(1) << (PHI_W - 1);

	typedef struct packed {
		p2c_pkg::quad_t        quad;
		logic                  fold;
		logic [RANGE_BITS-1:0] r;
	} side_t;

	logic [p2c_pkg::MODE_W-1:0] polar_mode_q;
	logic                       en;

	logic                  stage_vld_q [LAT];
	side_t                 stage_side_q [LAT];
	side_t                 side_in;

	logic [PHI_W-1:0]      b_in;
	logic [PHI_W-1:0]      phi_in;
	logic [PHI_W-1:0]      phi_s1;
	logic [Q_W-1:0]        theta_s3;
	logic [Q_W-1:0]        theta_d [MUL_LAT];
	logic [Q_W-1:0]        t2_s5;

	logic [Q_W-1:0]        st_c [N_TERMS+1];
	logic [Q_W-1:0]        ct_c [N_TERMS+1];
	logic [SUM_W-1:0]      ss_c [N_TERMS+1];
	logic [SUM_W-1:0]      cs_c [N_TERMS+1];
	logic [Q_W-1:0]        t2_c [N_TERMS];

	logic [Q_W-1:0]        s_fin, c_fin, sb, cb, sm, cm;
	logic [Q_W-1:0]        sm_s62, cm_s62;
	logic [SCL_W-1:0]      s_scl, c_scl;

	p2c_pkg::quad_t        out_quad;
	logic                  s_neg, c_neg, x_neg, y_neg;
	logic [SCL_W:0]        s_rnd, c_rnd;
	logic [OUT_W-1:0]      s_mag, c_mag, x_mag, y_mag;
	logic signed [OUT_W-1:0] x_val, y_val, x_s65, y_s65;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polar_mode_q <= '0;
		end else if (cfg_we) begin
			polar_mode_q <= cfg_data;
		end
	end

	// ---------------------------------------------------------------- flow control
	// Advance every stage together unless the output register holds an untaken result.
	assign en = !stage_vld_q[LAT-1] || cart.ready;
	assign polar.ready = en;

	// ---------------------------------------------------------------- octant fold
	// Split off the quadrant, then mirror the upper half of each quadrant onto [0, pi/4].
	assign b_in = polar.azimuth[PHI_W-1:0];
	always_comb begin
		side_in.quad = p2c_pkg::quad_t'(polar.azimuth[ANGLE_BITS-1 -: 2]);
		side_in.fold = b_in > EIGHTH;
		side_in.r    = polar.range_m;
		phi_in       = side_in.fold ? PHI_W'(QUARTER - {1'b0, b_in}) : b_in;
	end

	// valid bits and sideband: one entry per pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				stage_vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			stage_vld_q[0] <= polar.valid;
			for (int i = 1; i < LAT; i++) begin
				stage_vld_q[i] <= stage_vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_side_q[0] <= side_in;
			phi_s1          <= phi_in;
			for (int i = 1; i < LAT; i++) begin
				stage_side_q[i] <= stage_side_q[i-1];
			end
		end
	end

	// ---------------------------------------------------------------- angle scaling
	// theta = phi * (pi/2) / 2^(ANGLE_BITS-2), Q1.61
	p2c_mulw #(
		.A_W(PHI_W), .B_W(SUM_W), .SHIFT(PHI_W), .OUT_W(Q_W)
	) u_theta (
		.clk(clk), .en(en), .a(phi_s1), .b(p2c_pkg::HALF_PI), .p(theta_s3)
	);

	// theta squared
	p2c_mulw #(
		.A_W(Q_W), .B_W(Q_W), .SHIFT(p2c_pkg::FRAC), .OUT_W(Q_W)
	) u_sq (
		.clk(clk), .en(en), .a(theta_s3), .b(theta_s3), .p(t2_s5)
	);

	// hold theta alongside its square
	always_ff @(posedge clk) begin
		if (en) begin
			theta_d[0] <= theta_s3;
			for (int i = 1; i < MUL_LAT; i++) begin
				theta_d[i] <= theta_d[i-1];
			end
		end
	end

	// ---------------------------------------------------------------- series
	// Each term: next = floor(floor(prev * t2 / 2^61) / d), then add or subtract it.
	assign st_c[0] = theta_d[MUL_LAT-1];
	assign ct_c[0] = Q_W'(p2c_pkg::Q_ONE);
	assign ss_c[0] = SUM_W'(theta_d[MUL_LAT-1]);
	assign cs_c[0] = p2c_pkg::Q_ONE;
	assign t2_c[0] = t2_s5;

	for (genvar g = 0; g < N_TERMS; g++) begin : g_term
		logic [Q_W-1:0]   xs, xc;
		logic [SUM_W-1:0] ss_d [TERM_LAT];
		logic [SUM_W-1:0] cs_d [TERM_LAT];

		p2c_mulw #(
			.A_W(Q_W), .B_W(Q_W), .SHIFT(p2c_pkg::FRAC), .OUT_W(Q_W)
		) u_smul (
			.clk(clk), .en(en), .a(st_c[g]), .b(t2_c[g]), .p(xs)
		);
		p2c_mulw #(
			.A_W(Q_W), .B_W(p2c_pkg::RECIP_W), .SHIFT(p2c_pkg::RECIP_SHIFT), .OUT_W(Q_W)
		) u_sdiv (
			.clk(clk), .en(en), .a(xs), .b(p2c_pkg::SIN_RECIP[g]), .p(st_c[g+1])
		);
		p2c_mulw #(
			.A_W(Q_W), .B_W(Q_W), .SHIFT(p2c_pkg::FRAC), .OUT_W(Q_W)
		) u_cmul (
			.clk(clk), .en(en), .a(ct_c[g]), .b(t2_c[g]), .p(xc)
		);
		p2c_mulw #(
			.A_W(Q_W), .B_W(p2c_pkg::RECIP_W), .SHIFT(p2c_pkg::RECIP_SHIFT), .OUT_W(Q_W)
		) u_cdiv (
			.clk(clk), .en(en), .a(xc), .b(p2c_pkg::COS_RECIP[g]), .p(ct_c[g+1])
		);

		// hold the running sums until this term is ready
		always_ff @(posedge clk) begin
			if (en) begin
				ss_d[0] <= ss_c[g];
				cs_d[0] <= cs_c[g];
				for (int i = 1; i < TERM_LAT; i++) begin
					ss_d[i] <= ss_d[i-1];
					cs_d[i] <= cs_d[i-1];
				end
			end
		end

		if (g % 2 == 0) begin : g_sub
			assign ss_c[g+1] = ss_d[TERM_LAT-1] - SUM_W'(st_c[g+1]);
			assign cs_c[g+1] = cs_d[TERM_LAT-1] - SUM_W'(ct_c[g+1]);
		end else begin : g_add
			assign ss_c[g+1] = ss_d[TERM_LAT-1] + SUM_W'(st_c[g+1]);
			assign cs_c[g+1] = cs_d[TERM_LAT-1] + SUM_W'(ct_c[g+1]);
		end

		// carry theta squared on to the next term
		if (g < N_TERMS - 1) begin : g_t2
			logic [Q_W-1:0] t2_d [TERM_LAT];
			always_ff @(posedge clk) begin
				if (en) begin
					t2_d[0] <= t2_c[g];
					for (int i = 1; i < TERM_LAT; i++) begin
						t2_d[i] <= t2_d[i-1];
					end
				end
			end
			assign t2_c[g+1] = t2_d[TERM_LAT-1];
		end
	end

	// ---------------------------------------------------------------- quadrant select
	// Undo the octant fold, then rotate sine and cosine into the request's quadrant.
	always_comb begin
		s_fin = ss_c[N_TERMS][Q_W-1:0];
		c_fin = cs_c[N_TERMS][Q_W-1:0];
		sb    = stage_side_q[I_SERIES].fold ? c_fin : s_fin;
		cb    = stage_side_q[I_SERIES].fold ? s_fin : c_fin;
		unique case (stage_side_q[I_SERIES].quad) inside
			p2c_pkg::QUAD_I, p2c_pkg::QUAD_III: begin
				sm = sb;
				cm = cb;
			end
			default: begin
				sm = cb;
				cm = sb;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sm_s62 <= sm;
			cm_s62 <= cm;
		end
	end

	// ---------------------------------------------------------------- range product
	// floor(r * trig / 2^60); the last bit feeds round-half-up below
	p2c_mulw #(
		.A_W(RANGE_BITS), .B_W(Q_W), .SHIFT(p2c_pkg::FRAC - 1), .OUT_W(SCL_W)
	) u_sscl (
		.clk(clk), .en(en), .a(stage_side_q[I_SEL].r), .b(sm_s62), .p(s_scl)
	);
	p2c_mulw #(
		.A_W(RANGE_BITS), .B_W(Q_W), .SHIFT(p2c_pkg::FRAC - 1), .OUT_W(SCL_W)
	) u_cscl (
		.clk(clk), .en(en), .a(stage_side_q[I_SEL].r), .b(cm_s62), .p(c_scl)
	);

	// ---------------------------------------------------------------- round, orient, sign
	always_comb begin
		out_quad = stage_side_q[I_SCALE].quad;
		s_neg    = (out_quad == p2c_pkg::QUAD_III) || (out_quad == p2c_pkg::QUAD_IV);
		c_neg    = (out_quad == p2c_pkg::QUAD_II) || (out_quad == p2c_pkg::QUAD_III);
		s_rnd    = {1'b0, s_scl} + {{SCL_W{1'b0}}, 1'b1};
		c_rnd    = {1'b0, c_scl} + {{SCL_W{1'b0}}, 1'b1};
		s_mag    = s_rnd[SCL_W-1:1];
		c_mag    = c_rnd[SCL_W-1:1];
		if (polar_mode_q[p2c_pkg::MODE_SWAP]) begin
			x_mag = c_mag;
			x_neg = c_neg;
			y_mag = s_mag;
			y_neg = s_neg;
		end else begin
			x_mag = s_mag;
			x_neg = s_neg;
			y_mag = c_mag;
			y_neg = c_neg;
		end
		x_neg = x_neg ^ polar_mode_q[p2c_pkg::MODE_NEG_X];
		y_neg = y_neg ^ polar_mode_q[p2c_pkg::MODE_NEG_Y];
		x_val = x_neg ? signed'(-x_mag) : signed'(x_mag);
		y_val = y_neg ? signed'(-y_mag) : signed'(y_mag);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s65 <= x_val;
			y_s65 <= y_val;
		end
	end

	assign cart.valid = stage_vld_q[LAT-1];
	assign cart.x_out = x_s65;
	assign cart.y_out = y_s65;

endmodule

FILE: rtl/p2c_mulw.sv
// Module: two-stage wide unsigned multiplier with floor shift, built from 32x32 partial products.
module p2c_mulw #(
	parameter int A_W = 32,
	parameter int B_W = 32,
	parameter int SHIFT = 0,
	parameter int OUT_W = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [A_W-1:0]   a,
	input  logic [B_W-1:0]   b,
	output logic [OUT_W-1:0] p
);
	localparam int NA = (A_W + 31) / 32;
	localparam int NB = (B_W + 31) / 32;
	localparam int FULL_W = 32 * (NA + NB);

	logic [32*NA-1:0]  a_pad;
	logic [32*NB-1:0]  b_pad;
	logic [63:0]       pp_s1 [NA][NB];
	logic [FULL_W-1:0] sum;
	logic [OUT_W-1:0]  p_s2;

	assign a_pad = (32*NA)'(a);
	assign b_pad = (32*NB)'(b);

	// stage 1: partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= {32'd0, a_pad[32*i +: 32]} * {32'd0, b_pad[32*j +: 32]};
				end
			end
		end
	end

	// stage 2: align, add, drop the low bits
	always_comb begin
		sum = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum = sum + (FULL_W'(pp_s1[i][j]) << (32 * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= OUT_W'(sum >> SHIFT);
		end
	end

	assign p = p_s2;

endmodule

FILE: rtl/p2c_chk.sv
// Checker: port-level assertions for the polar to Cartesian converter, bound to the top level.
module p2c_chk #(
	parameter int RANGE_BITS = 20
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [RANGE_BITS:0] x_out,
	input logic signed [RANGE_BITS:0] y_out
);
	localparam logic [RANGE_BITS:0] MOST_NEG = {1'b1, {RANGE_BITS{1'b0}}};

	// hold a stalled result
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(x_out) && $stable(y_out))
		else $error("stalled result changed");

	// drop request ready while a result waits
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request accepted while output stalled");

	// advance whenever the output is free or taken
	a_free_output_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("request refused with output free");

	// magnitudes stay within the range, so the most negative code never appears
	a_magnitude_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (x_out != MOST_NEG) && (y_out != MOST_NEG))
		else $error("result magnitude beyond range");

endmodule

bind polar_to_cartesian_oriented_top p2c_chk #(
	.RANGE_BITS(RANGE_BITS)
) u_p2c_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(polar.valid),
	.in_ready(polar.ready),
	.out_valid(cart.valid),
	.out_ready(cart.ready),
	.x_out(cart.x_out),
	.y_out(cart.y_out)
);
